// ===== rtl/core/rilbp_pkg.sv =====
// rilbp_pkg: constants, register codes and the rotation-minimum function
// for the rotation-invariant 3x3 lbp block. no dependencies.
`default_nettype none

package rilbp_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int PIXEL_BITS = 8;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS = 8;
  localparam int HEIGHT_BITS = 12;
  localparam int CODE_BITS  = 8;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(128);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(3);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MIN    = WIDTH_BITS'(3);
  localparam logic [WIDTH_BITS-1:0]  WIDTH_MAX    = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MIN   = HEIGHT_BITS'(3);

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // smallest of the eight circular rotations of a pattern
  function automatic logic [CODE_BITS-1:0] min_rotation(input logic [CODE_BITS-1:0] pat);
    logic [CODE_BITS-1:0] best;
    logic [CODE_BITS-1:0] rot;
    best = pat;
    for (int k = 1; k < CODE_BITS; k++) begin
      rot = (pat << k) | (pat >> (CODE_BITS - k));
      if (rot < best) begin
        best = rot;
      end
    end
    return best;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rotation_invariant_lbp_3x3.sv =====
// rotation_invariant_lbp_3x3: top level, line store memory, 3x3 window and
// code pipeline with apb-style register port. depends on rilbp_pkg.
`default_nettype none

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------
//  input   | in        | in_valid/in_stall  | pixel[7:0]
//  output  | out       | out_valid/out_stall| lbp_code[7:0], row_last
//  config  | in/out    | apb psel/penable   | paddr[2:0], pwdata, prdata
//
// one pixel per clock sustained while the output is not stalled; its code
// passes line memory read, pattern stage and rotation-minimum stage into the
// output register. both line stores share one 16-bit wide synchronous memory,
// read at accept and written back when the item leaves the pattern stage.
// rst is synchronous; no clearing pass, line entries are written before use.
// a stalled output only backs up the input once all stages hold items.

module rotation_invariant_lbp_3x3
  import rilbp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_BITS-1:0]   paddr,
  input  wire logic [DATA_BITS-1:0]   pwdata,
  output logic      [DATA_BITS-1:0]   prdata,
  output logic                        pready,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [PIXEL_BITS-1:0]  pixel,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [CODE_BITS-1:0]   lbp_code,
  output logic                        row_last
);

  // registers
  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic [COL_BITS-1:0]    col_cnt;
  logic [HEIGHT_BITS-1:0] row_cnt;

  // line memory: upper line in the high half, lower line in the low half
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0] line_rd;

  // pattern stage
  logic                   s1_valid;
  logic                   s1_res;
  logic                   s1_last;
  logic [COL_BITS-1:0]    s1_col;
  logic [PIXEL_BITS-1:0]  s1_px;

  // window: [0..1] top row, [2..3] middle row, [4..5] bottom row
  logic [PIXEL_BITS-1:0]  win [6];

  // rotation stage
  logic                   s2_valid;
  logic                   s2_last;
  logic [CODE_BITS-1:0]   s2_pattern;

  logic                   cfg_write;
  logic [WIDTH_BITS-1:0]  eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;
  logic [COL_BITS-1:0]    col_last;
  logic                   in_fire;
  logic                   out_en;
  logic                   s2_free;
  logic                   s1_leave;
  logic                   s1_free;
  logic                   at_last;
  logic [COL_BITS-1:0]    col_next;
  logic [HEIGHT_BITS-1:0] row_next;
  logic [PIXEL_BITS-1:0]  tr;
  logic [PIXEL_BITS-1:0]  mr;
  logic [PIXEL_BITS-1:0]  ctr;
  logic [CODE_BITS-1:0]   pattern;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = DATA_BITS'(image_width);
      REG_HEIGHT: prdata = DATA_BITS'(image_height);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[WIDTH_BITS-1:0];
        REG_HEIGHT: image_height <= pwdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  always_comb begin
    if (image_width < WIDTH_MIN) begin
      eff_w = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      eff_w = WIDTH_MAX;
    end else begin
      eff_w = image_width;
    end
    eff_h    = (image_height < HEIGHT_MIN) ? HEIGHT_MIN : image_height;
    col_last = COL_BITS'(eff_w - WIDTH_BITS'(1));
  end

  // flow control, each stage moves when the one after it has room
  assign out_en   = !out_valid || !out_stall;
  assign s2_free  = !s2_valid || out_en;
  assign s1_leave = s1_valid && (!s1_res || s2_free);
  assign s1_free  = !s1_valid || s1_leave;
  assign in_stall = !s1_free;
  assign in_fire  = in_valid && s1_free;

  // column and row position of the arriving pixel
  always_comb begin
    at_last = (col_cnt == col_last);
    if (at_last) begin
      col_next = '0;
      if ({1'b0, row_cnt} + (HEIGHT_BITS+1)'(1) >= {1'b0, eff_h}) begin
        row_next = '0;
      end else begin
        row_next = row_cnt + HEIGHT_BITS'(1);
      end
    end else begin
      col_next = col_cnt + COL_BITS'(1);
      row_next = row_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (cfg_write) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_fire) begin
      col_cnt <= col_next;
      row_cnt <= row_next;
    end
  end

  // within a frame the write of column c lands before its next read, at least
  // three items later, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_rd <= line_mem[col_cnt];
    end
    if (s1_leave) begin
      line_mem[s1_col] <= {mr, s1_px};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res  <= (row_cnt >= HEIGHT_BITS'(2)) && (col_cnt >= COL_BITS'(2));
      s1_last <= at_last;
      s1_col  <= col_cnt;
      s1_px   <= pixel;
    end
  end

  assign tr  = line_rd[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mr  = line_rd[PIXEL_BITS-1:0];
  assign ctr = win[3];

  // clockwise from top-left, top-left in the msb
  always_comb begin
    pattern[7] = (win[0] >= ctr);
    pattern[6] = (win[1] >= ctr);
    pattern[5] = (tr     >= ctr);
    pattern[4] = (mr     >= ctr);
    pattern[3] = (s1_px  >= ctr);
    pattern[2] = (win[5] >= ctr);
    pattern[1] = (win[4] >= ctr);
    pattern[0] = (win[2] >= ctr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_leave) begin
      win[0] <= win[1];
      win[1] <= tr;
      win[2] <= win[3];
      win[3] <= mr;
      win[4] <= win[5];
      win[5] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_leave && s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_leave && s1_res) begin
      s2_pattern <= pattern;
      s2_last    <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_valid) begin
      lbp_code <= min_rotation(s2_pattern);
      row_last <= s2_last;
    end
  end

  // column position never runs past the clamped width
  assert property (@(posedge clk) disable iff (rst) col_cnt <= col_last)
    else $error("column count beyond image width");

  // a held rotation-stage item keeps its pattern until the output takes it
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_en |=> s2_valid && $stable(s2_pattern) && $stable(s2_last))
    else $error("rotation stage item lost or changed while held");

  // line write-back and a new read never hit the same entry in one cycle
  assert property (@(posedge clk) disable iff (rst)
    !(s1_leave && in_fire && (s1_col == col_cnt)))
    else $error("line memory read and write collide");

  // a border item never reaches the rotation stage
  assert property (@(posedge clk) disable iff (rst)
    s1_leave && !s1_res && s2_free |=> !s2_valid)
    else $error("border pixel produced a code");

endmodule

`default_nettype wire

// ===== tb/rotation_invariant_lbp_3x3_tb.sv =====
// rotation_invariant_lbp_3x3_tb: self-checking bench for the 3x3 rotation-invariant lbp block.
// predicts each code from its own line stores and window, then compares codes
// and row marks in order. depends on rilbp_pkg and rotation_invariant_lbp_3x3.
`timescale 1ns / 100ps

module rotation_invariant_lbp_3x3_tb;
  import rilbp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 last;
  } lbp_result_t;

  typedef enum {PIX_UNIFORM, PIX_NARROW, PIX_EXTREME} pixel_mix_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIXEL_BITS-1:0] pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CODE_BITS-1:0]  lbp_code;
  logic                  row_last;

  // predictor state
  logic [WIDTH_BITS-1:0]  cfg_width;
  logic [HEIGHT_BITS-1:0] cfg_height;
  logic [PIXEL_BITS-1:0]  upper_row [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]  lower_row [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]  window_px [6];
  int unsigned            col;
  int unsigned            row;
  lbp_result_t            expected_codes [$];

  // stimulus controls
  bit                     gap_on = 1'b0;
  bit                     stall_on = 1'b0;
  int                     hold_len = 0;
  int                     hold_seq = 0;
  logic [PIXEL_BITS-1:0]  narrow_base = '0;

  int                     hold_seen = 0;
  int                     hold_left = 0;
  int                     burst_left = 0;
  int                     errors = 0;
  int                     pixels_sent = 0;
  int                     codes_checked = 0;
  int                     registers_written = 0;
  int                     cycle_count = 0;
  lbp_result_t            head;

  rotation_invariant_lbp_3x3 u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .lbp_code  (lbp_code),
    .row_last  (row_last)
  );

  always #4 clk = ~clk;

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    errors++;
    if (errors <= 10) begin
      $display("error: %0s expected %0h got %0h", what, want, got);
    end
  endfunction

  function automatic logic [ADDR_BITS-1:0] reg_addr(input logic index);
    return ADDR_BITS'({index, 2'b00});
  endfunction

  function automatic int unsigned effective_width();
    if (cfg_width < WIDTH_MIN) return 32'(WIDTH_MIN);
    if (cfg_width > WIDTH_MAX) return 32'(WIDTH_MAX);
    return 32'(cfg_width);
  endfunction

  function automatic int unsigned effective_height();
    return (cfg_height < HEIGHT_MIN) ? 32'(HEIGHT_MIN) : 32'(cfg_height);
  endfunction

  // smallest value over all circular rotations, read from a doubled copy
  function automatic logic [CODE_BITS-1:0] rotation_floor(input logic [CODE_BITS-1:0] pat);
    logic [2*CODE_BITS-1:0] twice;
    logic [CODE_BITS-1:0]   best;
    logic [CODE_BITS-1:0]   cand;
    twice = {pat, pat};
    best = pat;
    for (int k = 1; k < CODE_BITS; k++) begin
      cand = twice[2*CODE_BITS-1-k -: CODE_BITS];
      if (cand < best) best = cand;
    end
    return best;
  endfunction

  function automatic void reset_model();
    cfg_width = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    foreach (upper_row[i]) upper_row[i] = '0;
    foreach (lower_row[i]) lower_row[i] = '0;
    foreach (window_px[i]) window_px[i] = '0;
    col = 0;
    row = 0;
  endfunction

  function automatic void store_register(input logic [ADDR_BITS-1:0] addr,
                                         input logic [DATA_BITS-1:0] data);
    if (addr[ADDR_BITS-1] == REG_HEIGHT) cfg_height = data[HEIGHT_BITS-1:0];
    else cfg_width = data[WIDTH_BITS-1:0];
    // any write restarts the frame
    col = 0;
    row = 0;
  endfunction

  function automatic void predict_pixel(input logic [PIXEL_BITS-1:0] px);
    int unsigned           w;
    int unsigned           h;
    int unsigned           c;
    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS-1:0] mid;
    logic [PIXEL_BITS-1:0] ctr;
    logic [CODE_BITS-1:0]  pat;
    lbp_result_t           res;
    w = effective_width();
    h = effective_height();
    c = (col >= w) ? w - 1 : col;
    up = upper_row[c];
    mid = lower_row[c];
    if (row >= 2 && c >= 2) begin
      ctr = window_px[3];
      // clockwise from top-left: tl t tr r br b bl l
      pat = {window_px[0] >= ctr, window_px[1] >= ctr, up >= ctr, mid >= ctr,
             px >= ctr, window_px[5] >= ctr, window_px[4] >= ctr, window_px[2] >= ctr};
      res.code = rotation_floor(pat);
      res.last = (c == w - 1);
      expected_codes.push_back(res);
    end
    window_px[0] = window_px[1];
    window_px[1] = up;
    window_px[2] = window_px[3];
    window_px[3] = mid;
    window_px[4] = window_px[5];
    window_px[5] = px;
    upper_row[c] = mid;
    lower_row[c] = px;
    if (c + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = c + 1;
    end
  endfunction

  function automatic logic [PIXEL_BITS-1:0] next_pixel(input pixel_mix_t mix);
    case (mix)
      PIX_NARROW:  return narrow_base + PIXEL_BITS'($urandom_range(0, 3));
      PIX_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      default:     return PIXEL_BITS'($urandom);
    endcase
  endfunction

  // every call starts just after the rising edge of clk
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] value);
    if (gap_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      pixel <= PIXEL_BITS'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= value;
    do @(posedge clk); while (in_stall);
    predict_pixel(value);
    pixels_sent++;
  endtask

  task automatic send_random(input int count, input pixel_mix_t mix);
    repeat (count) send_pixel(next_pixel(mix));
  endtask

  // items with no code may still be in flight when the last code leaves
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_register(input logic [ADDR_BITS-1:0] addr);
    logic [DATA_BITS-1:0] want;
    want = (addr[ADDR_BITS-1] == REG_HEIGHT) ? DATA_BITS'(cfg_height) : DATA_BITS'(cfg_width);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) note_mismatch("register readback", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_register(input logic [ADDR_BITS-1:0] addr,
                                input logic [DATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    store_register(addr, data);
    registers_written++;
    @(posedge clk);
    check_register(addr);
  endtask

  task automatic test_default_config();
    check_register(reg_addr(REG_WIDTH));
    check_register(reg_addr(REG_HEIGHT));
    gap_on = 1'b1;
    stall_on = 1'b1;
    send_random(3 * MAX_WIDTH, PIX_UNIFORM);
  endtask

  task automatic test_directed_patterns();
    logic [PIXEL_BITS-1:0] pixels [27];
    // all equal, alternating ring around a mid center, center above every neighbor
    pixels = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
               8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd0, 8'd255,
               8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd254, 8'd254, 8'd254, 8'd254};
    wait_idle();
    write_register(reg_addr(REG_WIDTH), DATA_BITS'(3));
    write_register(reg_addr(REG_HEIGHT), DATA_BITS'(3));
    gap_on = 1'b0;
    stall_on = 1'b1;
    foreach (pixels[i]) send_pixel(pixels[i]);
  endtask

  task automatic test_clamped_config();
    gap_on = 1'b1;
    stall_on = 1'b1;
    // widths and heights below the floor act as three
    for (int i = 0; i < 3; i++) begin
      wait_idle();
      write_register(reg_addr(REG_WIDTH), DATA_BITS'(i));
      write_register(reg_addr(REG_HEIGHT), DATA_BITS'(2 - i));
      send_random(9, PIX_UNIFORM);
    end
    // width above the line store size, junk above the register bits
    wait_idle();
    write_register(reg_addr(REG_WIDTH), {24'($urandom), 8'd129});
    write_register(reg_addr(REG_HEIGHT), {20'($urandom), 12'd3});
    send_random(3 * MAX_WIDTH, PIX_UNIFORM);
    // tallest frame, only its first rows
    wait_idle();
    write_register(reg_addr(REG_WIDTH), DATA_BITS'(3));
    write_register(reg_addr(REG_HEIGHT), {20'($urandom), 12'hfff});
    send_random(45, PIX_EXTREME);
  endtask

  task automatic test_random_frames(input int budget);
    int                     pick;
    int                     count;
    logic [WIDTH_BITS-1:0]  wval;
    logic [HEIGHT_BITS-1:0] hval;
    pixel_mix_t             mix;
    while (budget > 0) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) wval = WIDTH_BITS'($urandom_range(3, 12));
      else if (pick < 17) wval = WIDTH_BITS'($urandom_range(13, 48));
      else if (pick < 18) wval = WIDTH_MAX;
      else wval = WIDTH_BITS'($urandom_range(0, 255));
      hval = HEIGHT_BITS'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 6));
      narrow_base = PIXEL_BITS'($urandom_range(0, 252));
      mix = pixel_mix_t'($urandom_range(0, 2));
      gap_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      wait_idle();
      write_register(reg_addr(REG_WIDTH), {24'($urandom), wval});
      if ($urandom_range(0, 3) != 0) begin
        write_register(reg_addr(REG_HEIGHT), {20'($urandom), hval});
      end
      count = $urandom_range(3 * effective_width(), 2 * effective_width() * effective_height());
      if (count > 400) count = 400;
      if (count > budget) count = budget;
      send_random(count, mix);
      budget -= count;
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_register(reg_addr(REG_WIDTH), DATA_BITS'(10));
    write_register(reg_addr(REG_HEIGHT), DATA_BITS'(5));
    gap_on = 1'b0;
    stall_on = 1'b0;
    // long output hold while pixels keep coming, so the input backs up
    hold_len = 60;
    hold_seq++;
    send_random(100, PIX_UNIFORM);
    // sender holds off until every code is out
    wait_idle();
    gap_on = 1'b1;
    hold_len = 40;
    hold_seq++;
    send_random(60, PIX_NARROW);
    wait_idle();
  endtask

  task automatic test_quiet_tail();
    gap_on = 1'b0;
    stall_on = 1'b0;
    send_random(80, PIX_UNIFORM);
  endtask

  // output stall: long holds on request, short random bursts otherwise when stall_on is set
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        note_mismatch("unexpected code", 0, 32'(lbp_code));
      end else begin
        head = expected_codes.pop_front();
        codes_checked++;
        if (lbp_code !== head.code) note_mismatch("lbp_code", 32'(head.code), 32'(lbp_code));
        if (row_last !== head.last) note_mismatch("row_last", 32'(head.last), 32'(row_last));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d codes outstanding", cycle_count,
             expected_codes.size());
    $display("rotation_invariant_lbp_3x3: mismatch");
    $finish;
  end

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_config();
    test_directed_patterns();
    test_clamped_config();
    test_random_frames(800);
    test_backpressure();
    test_quiet_tail();
    wait_idle();
    $display("run: %0d pixels in, %0d codes checked, %0d register writes",
             pixels_sent, codes_checked, registers_written);
    $display("widths 3 to 128 incl. clamped values, heights up to 4095, stalls and holds");
    if (errors == 0) begin
      $display("rotation_invariant_lbp_3x3: match");
    end else begin
      $display("%0d mismatches", errors);
      $display("rotation_invariant_lbp_3x3: mismatch");
    end
    $finish;
  end

endmodule

// ===== rotation_invariant_lbp_3x3.f =====
rtl/core/rilbp_pkg.sv
rtl/core/rotation_invariant_lbp_3x3.sv
tb/rotation_invariant_lbp_3x3_tb.sv
